>>> rtl/hte_pkg.sv
package hte_pkg;

  // Default component width
  localparam int COLOR_BITS_DEF = 8;

  // Gain registers: signed Q.8, dead band unsigned Q.8
  localparam int GAIN_W = 11;
  localparam int BAND_W = 10;
  localparam int CFG_W  = GAIN_W;

  // Configuration register indexes
  localparam logic [2:0] REG_RED_GAIN     = 3'd0;
  localparam logic [2:0] REG_GREEN_GAIN   = 3'd1;
  localparam logic [2:0] REG_BLUE_GAIN    = 3'd2;
  localparam logic [2:0] REG_CYAN_GAIN    = 3'd3;
  localparam logic [2:0] REG_MAGENTA_GAIN = 3'd4;
  localparam logic [2:0] REG_YELLOW_GAIN  = 3'd5;
  localparam logic [2:0] REG_DEAD_BAND    = 3'd6;

  // Channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    GM_OFF,
    GM_POS,
    GM_NEG
  } gmode_t;

  typedef struct packed {
    logic [1:0] hi;
    logic [1:0] mid;
    logic [1:0] lo;
  } rank_t;

  typedef struct packed {
    rank_t  rank;
    gmode_t mode1;
    gmode_t mode2;
  } ctrl_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] red_gain;
    logic signed [GAIN_W-1:0] green_gain;
    logic signed [GAIN_W-1:0] blue_gain;
    logic signed [GAIN_W-1:0] cyan_gain;
    logic signed [GAIN_W-1:0] magenta_gain;
    logic signed [GAIN_W-1:0] yellow_gain;
    logic [BAND_W-1:0]        dead_band;
  } cfg_t;

  // Ordering from {R<G, R<B, G<B}; equal values favour red, then green
  function automatic rank_t rank_of(input logic [2:0] sel);
    rank_t r;
    case (sel)
      3'b001:  r = '{hi: CH_RED,   mid: CH_BLUE,  lo: CH_GREEN};
      3'b011:  r = '{hi: CH_BLUE,  mid: CH_RED,   lo: CH_GREEN};
      3'b100:  r = '{hi: CH_GREEN, mid: CH_RED,   lo: CH_BLUE};
      3'b110:  r = '{hi: CH_GREEN, mid: CH_BLUE,  lo: CH_RED};
      3'b111:  r = '{hi: CH_BLUE,  mid: CH_GREEN, lo: CH_RED};
      default: r = '{hi: CH_RED,   mid: CH_GREEN, lo: CH_BLUE};
    endcase
    return r;
  endfunction

endpackage

>>> rtl/hte_order.sv
module hte_order
  import hte_pkg::*;
#(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic [COLOR_BITS-1:0]   red,
  input  logic [COLOR_BITS-1:0]   green,
  input  logic [COLOR_BITS-1:0]   blue,
  input  cfg_t                    cfg,
  output ctrl_t                   ctrl,
  output logic [COLOR_BITS-1:0]   hi_val,
  output logic [COLOR_BITS-1:0]   mid_val,
  output logic [COLOR_BITS-1:0]   lo_val,
  output logic [COLOR_BITS+2:0]   q1,
  output logic [COLOR_BITS+2:0]   q2
);

  localparam int PW = COLOR_BITS + GAIN_W;

  rank_t                    rank;
  logic signed [GAIN_W-1:0] g1;
  logic signed [GAIN_W-1:0] g2;
  logic signed [GAIN_W:0]   g1x;
  logic signed [GAIN_W:0]   g2x;
  logic signed [GAIN_W:0]   band;
  logic signed [GAIN_W:0]   g1abs;
  logic signed [GAIN_W:0]   g2abs;
  logic                     act1;
  logic                     act2;
  logic [COLOR_BITS-1:0]    d1;
  logic [COLOR_BITS-1:0]    d2;
  logic [PW-1:0]            p1;
  logic [PW-1:0]            p2;

  function automatic logic [COLOR_BITS-1:0] pick(
    input logic [1:0]            idx,
    input logic [COLOR_BITS-1:0] r,
    input logic [COLOR_BITS-1:0] g,
    input logic [COLOR_BITS-1:0] b
  );
    logic [COLOR_BITS-1:0] v;
    case (idx)
      CH_RED:   v = r;
      CH_GREEN: v = g;
      default:  v = b;
    endcase
    return v;
  endfunction

  // Order the channels
  assign rank    = rank_of({red < green, red < blue, green < blue});
  assign hi_val  = pick(rank.hi, red, green, blue);
  assign mid_val = pick(rank.mid, red, green, blue);
  assign lo_val  = pick(rank.lo, red, green, blue);
  assign d1      = hi_val - mid_val;
  assign d2      = mid_val - lo_val;

  // Select the primary gain of the largest and the secondary gain of the smallest
  always_comb begin
    case (rank.hi)
      CH_RED:   g1 = cfg.red_gain;
      CH_GREEN: g1 = cfg.green_gain;
      default:  g1 = cfg.blue_gain;
    endcase
    case (rank.lo)
      CH_RED:   g2 = cfg.cyan_gain;
      CH_GREEN: g2 = cfg.magenta_gain;
      default:  g2 = cfg.yellow_gain;
    endcase
  end

  // Apply the dead band
  assign g1x   = {g1[GAIN_W-1], g1};
  assign g2x   = {g2[GAIN_W-1], g2};
  assign band  = $signed({2'b00, cfg.dead_band});
  assign act1  = (g1x > band) || (g1x < -band);
  assign act2  = (g2x > band) || (g2x < -band);
  assign g1abs = g1x[GAIN_W] ? -g1x : g1x;
  assign g2abs = g2x[GAIN_W] ? -g2x : g2x;

  always_comb begin
    ctrl.rank  = rank;
    ctrl.mode1 = !act1 ? GM_OFF : (g1[GAIN_W-1] ? GM_NEG : GM_POS);
    ctrl.mode2 = !act2 ? GM_OFF : (g2[GAIN_W-1] ? GM_NEG : GM_POS);
  end

  // Scale the gaps by the gain magnitudes, drop the Q.8 fraction
  assign p1 = PW'(g1abs[GAIN_W-1:0]) * PW'(d1);
  assign p2 = PW'(g2abs[GAIN_W-1:0]) * PW'(d2);
  assign q1 = p1[PW-1:8];
  assign q2 = p2[PW-1:8];

endmodule

>>> rtl/hte_div3.sv
module hte_div3 #(
  parameter int W = 11
) (
  input  logic [W-1:0] num,
  output logic [W-1:0] quot
);

  localparam logic [63:0]  RECIP_FULL = (64'd1 << W) / 64'd3;
  localparam logic [W-1:0] RECIP      = RECIP_FULL[W-1:0];

  logic [2*W-1:0] prod;
  logic [W-1:0]   est;
  logic [W-1:0]   rem;

  // Estimate by reciprocal, short by at most one
  assign prod = (2*W)'(num) * (2*W)'(RECIP);
  assign est  = prod[2*W-1:W];
  assign rem  = num - (est + (est << 1));

  // Correct the estimate
  assign quot = (rem >= W'(3)) ? est + W'(1) : est;

endmodule

>>> rtl/hte_adjust.sv
module hte_adjust
  import hte_pkg::*;
#(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  ctrl_t                 ctrl,
  input  logic [COLOR_BITS-1:0] hi_val,
  input  logic [COLOR_BITS-1:0] mid_val,
  input  logic [COLOR_BITS-1:0] lo_val,
  input  logic [COLOR_BITS+2:0] q1,
  input  logic [COLOR_BITS+2:0] q2,
  output logic [COLOR_BITS-1:0] red,
  output logic [COLOR_BITS-1:0] green,
  output logic [COLOR_BITS-1:0] blue
);

  localparam int QW = COLOR_BITS + 3;
  localparam int W  = COLOR_BITS + 5;
  localparam logic signed [W-1:0] MAXV = $signed({{(W-COLOR_BITS){1'b0}}, {COLOR_BITS{1'b1}}});

  logic [QW-1:0]         t1u;
  logic [QW-1:0]         t2u;
  logic signed [W-1:0]   hv, mv, lv;
  logic signed [W-1:0]   a1, a2, t1, t2;
  logic signed [W-1:0]   h1, m1, l1, mt;
  logic signed [W-1:0]   h2, m2, l2, mu, lu;
  logic [COLOR_BITS-1:0] hc, mc, lc;

  function automatic logic [COLOR_BITS-1:0] clampv(input logic signed [W-1:0] v);
    logic [COLOR_BITS-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > MAXV) begin
      c = {COLOR_BITS{1'b1}};
    end else begin
      c = v[COLOR_BITS-1:0];
    end
    return c;
  endfunction

  // Thirds of the scaled gaps for the shrinking case
  hte_div3 #(.W(QW)) u_div1 (.num(q1), .quot(t1u));
  hte_div3 #(.W(QW)) u_div2 (.num(q2), .quot(t2u));

  assign hv = $signed({{(W-COLOR_BITS){1'b0}}, hi_val});
  assign mv = $signed({{(W-COLOR_BITS){1'b0}}, mid_val});
  assign lv = $signed({{(W-COLOR_BITS){1'b0}}, lo_val});
  assign a1 = $signed({{(W-QW){1'b0}}, q1});
  assign a2 = $signed({{(W-QW){1'b0}}, q2});
  assign t1 = $signed({{(W-QW){1'b0}}, t1u});
  assign t2 = $signed({{(W-QW){1'b0}}, t2u});

  // Stage one: widen or shrink the largest-middle gap
  always_comb begin
    mt = mv - a1;
    case (ctrl.mode1)
      GM_POS: begin
        h1 = hv + a1;
        m1 = (mt < lv) ? lv : mt;
        l1 = lv;
      end
      GM_NEG: begin
        h1 = hv - (t1 <<< 1);
        m1 = mv + t1;
        l1 = lv + t1;
      end
      default: begin
        h1 = hv;
        m1 = mv;
        l1 = lv;
      end
    endcase
  end

  // Stage two: widen or shrink the middle-smallest gap
  always_comb begin
    mu = m1 + a2;
    lu = l1 - a2;
    case (ctrl.mode2)
      GM_POS: begin
        h2 = h1;
        m2 = (mu > h1) ? h1 : mu;
        l2 = (lu < 0) ? '0 : lu;
      end
      GM_NEG: begin
        h2 = h1 - t2;
        m2 = m1 - t2;
        l2 = l1 + (t2 <<< 1);
      end
      default: begin
        h2 = h1;
        m2 = m1;
        l2 = l1;
      end
    endcase
  end

  // Clamp and return each rank to its channel
  assign hc = clampv(h2);
  assign mc = clampv(m2);
  assign lc = clampv(l2);

  assign red   = (ctrl.rank.hi == CH_RED)   ? hc : (ctrl.rank.mid == CH_RED)   ? mc : lc;
  assign green = (ctrl.rank.hi == CH_GREEN) ? hc : (ctrl.rank.mid == CH_GREEN) ? mc : lc;
  assign blue  = (ctrl.rank.hi == CH_BLUE)  ? hc : (ctrl.rank.mid == CH_BLUE)  ? mc : lc;

endmodule

>>> rtl/hue_tone_enhance_top.sv
// Throughput: one pixel per clock while the output is not stalled by m_tready;
// the gain multipliers feed a product register and the divide-by-three and clamp
// logic feed the output register.
// Each register accepts while empty or while its contents move on.
// Reset (synchronous, rst high) empties both stages and clears every gain
// and the dead band to zero.
module hue_tone_enhance_top
  import hte_pkg::*;
#(
  parameter int COLOR_BITS = COLOR_BITS_DEF,
  parameter int DATA_W     = ((3 * COLOR_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration write port
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // Input pixel stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,  // in_red, in_green, in_blue, zero pad
  // Output pixel stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata   // out_red, out_green, out_blue, zero pad
);

  localparam int CB = COLOR_BITS;
  localparam int QW = COLOR_BITS + 3;

  cfg_t            cfg;
  ctrl_t           ctrl_a;
  ctrl_t           ctrl1;
  logic [CB-1:0]   hi_a, mid_a, lo_a;
  logic [CB-1:0]   hi1, mid1, lo1;
  logic [QW-1:0]   q1_a, q2_a;
  logic [QW-1:0]   q1r, q2r;
  logic            v1;
  logic            ready2;
  logic            in_fire;
  logic [CB-1:0]   red_b, green_b, blue_b;
  logic [3*CB-1:0] out_pix;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED_GAIN:     cfg.red_gain     <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GREEN_GAIN:   cfg.green_gain   <= $signed(cfg_data[GAIN_W-1:0]);
        REG_BLUE_GAIN:    cfg.blue_gain    <= $signed(cfg_data[GAIN_W-1:0]);
        REG_CYAN_GAIN:    cfg.cyan_gain    <= $signed(cfg_data[GAIN_W-1:0]);
        REG_MAGENTA_GAIN: cfg.magenta_gain <= $signed(cfg_data[GAIN_W-1:0]);
        REG_YELLOW_GAIN:  cfg.yellow_gain  <= $signed(cfg_data[GAIN_W-1:0]);
        REG_DEAD_BAND:    cfg.dead_band    <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: each stage advances when empty or when its successor advances
  assign ready2   = !m_tvalid || m_tready;
  assign s_tready = !v1 || ready2;
  assign in_fire  = s_tvalid && s_tready;

  // Order, select gains, multiply
  hte_order #(.COLOR_BITS(CB)) u_order (
    .red     (s_tdata[CB-1:0]),
    .green   (s_tdata[2*CB-1:CB]),
    .blue    (s_tdata[3*CB-1:2*CB]),
    .cfg     (cfg),
    .ctrl    (ctrl_a),
    .hi_val  (hi_a),
    .mid_val (mid_a),
    .lo_val  (lo_a),
    .q1      (q1_a),
    .q2      (q2_a)
  );

  // Hold products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctrl1 <= ctrl_a;
      hi1   <= hi_a;
      mid1  <= mid_a;
      lo1   <= lo_a;
      q1r   <= q1_a;
      q2r   <= q2_a;
    end
  end

  // Apply both gain stages and clamp
  hte_adjust #(.COLOR_BITS(CB)) u_adjust (
    .ctrl    (ctrl1),
    .hi_val  (hi1),
    .mid_val (mid1),
    .lo_val  (lo1),
    .q1      (q1r),
    .q2      (q2r),
    .red     (red_b),
    .green   (green_b),
    .blue    (blue_b)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready2) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      out_pix <= {blue_b, green_b, red_b};
    end
  end

  assign m_tdata = DATA_W'(out_pix);

  // Checks
  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    in_fire |=> v1)
    else $error("accepted transaction not held in product stage");

  a_advance : assert property (@(posedge clk) disable iff (rst)
    (v1 && ready2) |=> m_tvalid)
    else $error("product stage did not move to output");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (v1 && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are blocked");

  a_rank_distinct : assert property (@(posedge clk) disable iff (rst)
    v1 |-> (ctrl1.rank.hi != ctrl1.rank.mid) && (ctrl1.rank.hi != ctrl1.rank.lo)
           && (ctrl1.rank.mid != ctrl1.rank.lo))
    else $error("channel ranks not distinct");

endmodule
